/* rtl/lobc_pkg.sv */
// ============================================================================
// lobc_pkg
// Shared types, codes and sizes of the LED on/off/breathing controller.
// ============================================================================
package lobc_pkg;

    // Width of the flash elapsed-time counter (8 to 32).
    localparam int TIMER_BITS = 17;
    // Width of the breathing step elapsed-time counter.
    localparam int PULSE_BITS = 9;
    // Width used to compare the flash counter against its interval.
    localparam int FLASH_CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP      = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_FLASH_INTERVAL = 16'd1000;
    localparam logic [7:0]  RST_PULSE_INTERVAL = 8'd10;
    localparam logic [7:0]  RST_LOW_LEVEL      = 8'd0;
    localparam logic [7:0]  RST_HIGH_LEVEL     = 8'd255;
    localparam logic [6:0]  RST_FADE_STEP      = 7'd5;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ON    = 3'd1,
        CMD_OFF   = 3'd2,
        CMD_FLASH = 3'd3,
        CMD_PULSE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_ON        = 3'd1,
        MODE_OFF       = 3'd2,
        MODE_FLASH_ON  = 3'd3,
        MODE_FLASH_OFF = 3'd4,
        MODE_PULSE     = 3'd5
    } t_mode;

    typedef struct packed {
        logic [15:0] flash_interval_ms;
        logic [7:0]  pulse_interval_ms;
        logic [7:0]  low_level;
        logic [7:0]  high_level;
        logic [6:0]  fade_step;
    } t_cfg;

endpackage

/* rtl/lobc_in_if.sv */
// ============================================================================
// lobc_in_if
// Input channel: a command or a millisecond tick per beat.
// ============================================================================
interface lobc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       normal_state;

    modport source (output valid, output command, output normal_state, input ready);
    modport sink   (input valid, input command, input normal_state, output ready);
endinterface

/* rtl/lobc_out_if.sv */
// ============================================================================
// lobc_out_if
// Result channel: LED level, write flag and current mode per beat.
// ============================================================================
interface lobc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_level;
    logic       level_written;
    logic [2:0] mode_now;

    modport source (output valid, output led_level, output level_written,
                    output mode_now, input ready);
    modport sink   (input valid, input led_level, input level_written,
                    input mode_now, output ready);
endinterface

/* rtl/lobc_cfg.sv */
// ============================================================================
// lobc_cfg
// Configuration register file written through a plain write port.
// ============================================================================
module lobc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [lobc_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [lobc_pkg::CFG_DATA_W-1:0] i_data,
    output lobc_pkg::t_cfg                 o_cfg
);
    import lobc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_interval_ms <= RST_FLASH_INTERVAL;
            r_cfg.pulse_interval_ms <= RST_PULSE_INTERVAL;
            r_cfg.low_level         <= RST_LOW_LEVEL;
            r_cfg.high_level        <= RST_HIGH_LEVEL;
            r_cfg.fade_step         <= RST_FADE_STEP;
        end else if (i_we) begin
            case (i_index)
                REG_FLASH_INTERVAL: r_cfg.flash_interval_ms <= i_data;
                REG_PULSE_INTERVAL: r_cfg.pulse_interval_ms <= i_data[7:0];
                REG_LOW_LEVEL:      r_cfg.low_level         <= i_data[7:0];
                REG_HIGH_LEVEL:     r_cfg.high_level        <= i_data[7:0];
                REG_FADE_STEP:      r_cfg.fade_step         <= i_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/lobc_core.sv */
// ============================================================================
// lobc_core
// Mode state machine, elapsed-time counters and breathing fader, updated
// once per accepted beat, with the registered result.
// ============================================================================
module lobc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lobc_pkg::t_cfg i_cfg,
    input  logic           i_acc,
    input  logic [2:0]     i_cmd,
    input  logic           i_normal,
    output logic [7:0]     o_level,
    output logic           o_written,
    output logic [2:0]     o_mode
);
    import lobc_pkg::*;

    t_mode                  r_mode, n_mode;
    logic [TIMER_BITS-1:0]  r_flash_el, n_flash_el;
    logic [PULSE_BITS-1:0]  r_pulse_el, n_pulse_el;
    logic signed [9:0]      r_bright, n_bright;
    logic                   r_falling, n_falling;
    logic [7:0]             r_drive, n_drive;
    logic                   n_written;
    logic                   r_written;
    logic [7:0]             r_level;
    logic [2:0]             r_mode_out;

    logic [TIMER_BITS-1:0]  w_flash_inc;
    logic [PULSE_BITS-1:0]  w_pulse_inc;
    logic signed [10:0]     w_sum;
    logic signed [9:0]      w_step_b;
    logic [7:0]             w_bright_sat;

    always_comb begin
        w_flash_inc = (r_flash_el == '1) ? r_flash_el : r_flash_el + 1'b1;
        w_pulse_inc = (r_pulse_el == '1) ? r_pulse_el : r_pulse_el + 1'b1;

        // Breathing step: move by fade_step, clamp to the 10-bit signed range.
        w_sum = r_falling ? ({r_bright[9], r_bright} - {4'b0, i_cfg.fade_step})
                          : ({r_bright[9], r_bright} + {4'b0, i_cfg.fade_step});
        if (w_sum > 11'sd511) begin
            w_step_b = 10'sd511;
        end else if (w_sum < -11'sd512) begin
            w_step_b = -10'sd512;
        end else begin
            w_step_b = w_sum[9:0];
        end

        if (r_bright < 10'sd0) begin
            w_bright_sat = 8'd0;
        end else if (r_bright > 10'sd255) begin
            w_bright_sat = 8'd255;
        end else begin
            w_bright_sat = r_bright[7:0];
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_flash_el = r_flash_el;
        n_pulse_el = r_pulse_el;
        n_bright   = r_bright;
        n_falling  = r_falling;
        n_drive    = r_drive;
        n_written  = 1'b0;
        case (i_cmd)
            CMD_TICK: begin
                n_flash_el = w_flash_inc;
                n_pulse_el = w_pulse_inc;
                case (r_mode)
                    MODE_ON: begin
                        n_drive   = 8'd255;
                        n_written = 1'b1;
                        n_mode    = MODE_IDLE;
                    end
                    MODE_OFF: begin
                        n_drive   = 8'd0;
                        n_written = 1'b1;
                        n_mode    = MODE_IDLE;
                    end
                    MODE_FLASH_ON: begin
                        n_drive   = 8'd255;
                        n_written = 1'b1;
                        if (FLASH_CMP_W'(w_flash_inc) > FLASH_CMP_W'(i_cfg.flash_interval_ms))
                        begin
                            n_mode = MODE_OFF;
                        end
                    end
                    MODE_FLASH_OFF: begin
                        n_drive   = 8'd0;
                        n_written = 1'b1;
                        if (FLASH_CMP_W'(w_flash_inc) > FLASH_CMP_W'(i_cfg.flash_interval_ms))
                        begin
                            n_mode = MODE_PULSE;
                        end
                    end
                    MODE_PULSE: begin
                        if (w_pulse_inc > {1'b0, i_cfg.pulse_interval_ms}) begin
                            n_drive    = w_bright_sat;
                            n_written  = 1'b1;
                            n_bright   = w_step_b;
                            n_pulse_el = '0;
                            if (w_step_b <= $signed({2'b0, i_cfg.low_level}) ||
                                w_step_b >= $signed({2'b0, i_cfg.high_level})) begin
                                n_falling = ~r_falling;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_ON:  n_mode = MODE_ON;
            CMD_OFF: n_mode = MODE_OFF;
            CMD_FLASH: begin
                n_mode     = i_normal ? MODE_FLASH_ON : MODE_FLASH_OFF;
                n_flash_el = '0;
            end
            CMD_PULSE: n_mode = i_normal ? MODE_PULSE : MODE_OFF;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_flash_el <= '0;
            r_pulse_el <= '0;
            r_bright   <= '0;
            r_falling  <= 1'b0;
            r_drive    <= '0;
        end else if (i_acc) begin
            r_mode     <= n_mode;
            r_flash_el <= n_flash_el;
            r_pulse_el <= n_pulse_el;
            r_bright   <= n_bright;
            r_falling  <= n_falling;
            r_drive    <= n_drive;
        end
    end

    // Result register; its valid bit lives in the top level.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_level    <= n_drive;
            r_written  <= n_written;
            r_mode_out <= n_mode;
        end
    end

    assign o_level   = r_level;
    assign o_written = r_written;
    assign o_mode    = r_mode_out;

`ifndef ASSERT_OFF
    a_cmd_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_cmd != CMD_TICK |=> !r_written && r_drive == $past(r_drive))
        else $error("command beat rewrote the LED drive");

    a_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_cmd == CMD_TICK && r_mode == MODE_ON
        |=> r_written && r_level == 8'd255 && r_mode == MODE_IDLE)
        else $error("tick in on mode did not drive full and go idle");

    a_flash_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_cmd == CMD_FLASH |=> r_flash_el == '0)
        else $error("flash command did not clear its timer");

    a_result_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |=> r_level == r_drive && r_mode_out == r_mode)
        else $error("result register out of step with state");
`endif

endmodule

/* rtl/led_on_off_breathing_controller_top.sv */
// ============================================================================
// led_on_off_breathing_controller_top
// LED on/off, timed flash and breathing fade controller.
// ============================================================================
// Every input beat is either a one-millisecond tick or a command (on, off,
// timed flash, pulse), and every input beat produces exactly one result
// beat carrying the LED drive level, a flag that tells whether this beat
// rewrote the drive, and the mode after the beat. The whole state update
// is one pass of logic from the input handshake into the state and result
// registers, so a new beat is accepted in every cycle while the result side
// keeps taking beats. The result register holds one finished beat; the
// input is stalled only while that beat waits and the result sink is not
// ready. Configuration registers (flash interval, pulse interval, low and
// high fade limits, fade step) are written through the plain write port,
// indexes 0 to 4 in that order, and should be changed only while no beat
// is in flight.
// ============================================================================
module led_on_off_breathing_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lobc_in_if.sink                          i_in,
    lobc_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [lobc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lobc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lobc_pkg::*;

    t_cfg w_cfg;
    logic w_acc;
    logic r_out_valid;

    // The input is free whenever the result register is empty or is being
    // emptied in this same cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    lobc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lobc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_acc     (w_acc),
        .i_cmd     (i_in.command),
        .i_normal  (i_in.normal_state),
        .o_level   (o_out.led_level),
        .o_written (o_out.level_written),
        .o_mode    (o_out.mode_now)
    );

    assign o_out.valid = r_out_valid;

endmodule

/* bench/led_result_checker.sv */
// ============================================================================
// led_result_checker
// Watches the command and result channels of the LED controller, predicts
// each result beat from its own copy of the mode, timers, fade state and
// settings, and compares the results in order.
// ============================================================================
module led_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lobc_in_if                              in_ch,
    lobc_out_if                             out_ch,
    input  logic                            i_cfg_we,
    input  logic [lobc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lobc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lobc_pkg::*;

    localparam logic [7:0] LED_DARK = 8'd0;
    localparam logic [7:0] LED_FULL = 8'd255;
    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] led_level;
        logic       level_written;
        logic [2:0] mode_now;
    } t_led_result;

    t_cfg                   settings;
    t_mode                  led_mode;
    logic [TIMER_BITS-1:0]  flash_ms;
    logic [PULSE_BITS-1:0]  pulse_ms;
    logic signed [9:0]      fade_level;
    logic                   fade_down;
    logic [7:0]             drive;

    t_led_result expected_results[$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void clear_led_state();
        settings.flash_interval_ms = RST_FLASH_INTERVAL;
        settings.pulse_interval_ms = RST_PULSE_INTERVAL;
        settings.low_level         = RST_LOW_LEVEL;
        settings.high_level        = RST_HIGH_LEVEL;
        settings.fade_step         = RST_FADE_STEP;
        led_mode   = MODE_IDLE;
        flash_ms   = '0;
        pulse_ms   = '0;
        fade_level = '0;
        fade_down  = 1'b0;
        drive      = LED_DARK;
    endfunction

    // One breathing step: move, clamp to the 10-bit signed range, and turn
    // around at or beyond either limit.
    function automatic void step_fade();
        int lvl;
        int stride;
        lvl    = int'(fade_level);
        stride = int'(settings.fade_step);
        lvl    = fade_down ? lvl - stride : lvl + stride;
        if (lvl > 511) lvl = 511;
        if (lvl < -512) lvl = -512;
        fade_level = 10'(lvl);
        if (lvl <= int'(settings.low_level) || lvl >= int'(settings.high_level))
            fade_down = !fade_down;
    endfunction

    function automatic t_led_result predict_led_beat(logic [2:0] cmd, logic normal);
        t_led_result res;
        int          lvl;
        res.level_written = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (flash_ms != '1) flash_ms = flash_ms + 1'b1;
                if (pulse_ms != '1) pulse_ms = pulse_ms + 1'b1;
                case (led_mode)
                    MODE_ON: begin
                        drive = LED_FULL;
                        res.level_written = 1'b1;
                        led_mode = MODE_IDLE;
                    end
                    MODE_OFF: begin
                        drive = LED_DARK;
                        res.level_written = 1'b1;
                        led_mode = MODE_IDLE;
                    end
                    MODE_FLASH_ON: begin
                        drive = LED_FULL;
                        res.level_written = 1'b1;
                        if (flash_ms > settings.flash_interval_ms) led_mode = MODE_OFF;
                    end
                    MODE_FLASH_OFF: begin
                        drive = LED_DARK;
                        res.level_written = 1'b1;
                        if (flash_ms > settings.flash_interval_ms) led_mode = MODE_PULSE;
                    end
                    MODE_PULSE: begin
                        if (pulse_ms > settings.pulse_interval_ms) begin
                            lvl = int'(fade_level);
                            drive = (lvl < 0) ? LED_DARK : (lvl > 255) ? LED_FULL : 8'(lvl);
                            res.level_written = 1'b1;
                            step_fade();
                            pulse_ms = '0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_ON:  led_mode = MODE_ON;
            CMD_OFF: led_mode = MODE_OFF;
            CMD_FLASH: begin
                led_mode = normal ? MODE_FLASH_ON : MODE_FLASH_OFF;
                flash_ms = '0;
            end
            CMD_PULSE: led_mode = normal ? MODE_PULSE : MODE_OFF;
            default: ;
        endcase
        res.led_level = drive;
        res.mode_now  = led_mode;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_led_result want;
        t_led_result got;
        if (!i_rst_n) begin
            clear_led_state();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FLASH_INTERVAL: settings.flash_interval_ms = i_cfg_data[15:0];
                    REG_PULSE_INTERVAL: settings.pulse_interval_ms = i_cfg_data[7:0];
                    REG_LOW_LEVEL:      settings.low_level         = i_cfg_data[7:0];
                    REG_HIGH_LEVEL:     settings.high_level        = i_cfg_data[7:0];
                    REG_FADE_STEP:      settings.fade_step         = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // A result always trails its command, so the result side is settled
            // before this edge's command is predicted.
            if (out_ch.valid && out_ch.ready) begin
                got.led_level     = out_ch.led_level;
                got.level_written = out_ch.level_written;
                got.mode_now      = out_ch.mode_now;
                if (expected_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result: level %0d written %0b mode %0d",
                                 $realtime, got.led_level, got.level_written, got.mode_now);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.led_level !== want.led_level ||
                        got.level_written !== want.level_written ||
                        got.mode_now !== want.mode_now) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                                     $realtime, want.led_level, want.level_written,
                                     want.mode_now, got.led_level, got.level_written,
                                     got.mode_now);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_led_beat(in_ch.command, in_ch.normal_state));
        end
        pending_count = expected_results.size();
    end

endmodule

/* bench/tb_led_on_off_breathing_controller_top.sv */
// ============================================================================
// tb_led_on_off_breathing_controller_top
// Stimulus and verdict for the LED on/off, timed flash and breathing
// controller: directed commands first, then phases of random command and
// tick sequences under several register settings, with random idle cycles on
// both channels and one long result-side stall.
// ============================================================================
module tb_led_on_off_breathing_controller_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lobc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    // Length of the deliberate result-side stall, in cycles.
    localparam int HOLD_CYCLES   = 60;
    // Quiet cycles after the last result before a register write or the verdict.
    localparam int SETTLE_CYCLES = 4;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // Command codes the block has no meaning for; it must ignore them.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    // A register index past the last real register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_SCATTER,
        RX_RUNS
    } t_rx_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    // Handshake pacing shared between the stimulus and the result-side process.
    t_rx_style rx_style = RX_ALWAYS;
    bit        tx_steady = 1'b0;
    int        holds_requested = 0;
    int        burst_left = 0;
    int        phase_items = 0;
    int        cur_flash_ms = 0;
    int        cur_pulse_ms = 0;

    lobc_in_if  in_ch();
    lobc_out_if out_ch();

    led_on_off_breathing_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    led_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // The whole run is bounded; a hung handshake ends here.
    initial begin
        #RUN_LIMIT_NS;
        $display("tb_led_on_off_breathing_controller_top failed");
        $finish;
    end

    // Result side. Ready changes only on the falling edge. A stall requested
    // by the stimulus is served first and counted down here; otherwise ready
    // follows the current style: always high, scattered single-cycle drops,
    // or alternating runs of ready and not ready.
    initial begin
        int hold_left;
        int holds_served;
        int run_left;
        bit run_ready;
        hold_left    = 0;
        holds_served = 0;
        run_left     = 0;
        run_ready    = 1'b1;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_requested) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                if (run_left == 0) begin
                    case (rx_style)
                        RX_SCATTER: begin
                            run_ready = ($urandom_range(0, 3) != 0);
                            run_left  = 1;
                        end
                        RX_RUNS: begin
                            run_ready = !run_ready;
                            run_left  = $urandom_range(1, 12);
                        end
                        default: begin
                            run_ready = 1'b1;
                            run_left  = 1;
                        end
                    endcase
                end
                out_ch.ready = run_ready;
                run_left--;
            end
        end
    end

    // Offers one beat and returns at the rising edge that accepts it. Unless
    // the sender is steady, beats go out in bursts of random length, and
    // before each burst valid drops for a random gap (often none) while the
    // payload lines carry junk.
    task automatic send_beat(input logic [2:0] cmd, input logic normal);
        int gap;
        if (!tx_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid        = 1'b0;
                in_ch.command      = 3'($urandom);
                in_ch.normal_state = 1'($urandom);
            end
        end
        @(negedge i_clk);
        in_ch.valid        = 1'b1;
        in_ch.command      = cmd;
        in_ch.normal_state = normal;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        phase_items++;
    endtask

    // Drops valid and waits until every expected result has come back, so
    // that the block is idle for register writes or the verdict. Each beat
    // yields exactly one result, so nothing is left in flight after that.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_settings(input int flash_ms, input int pulse_ms, input int low,
                                 input int high, input int step);
        write_reg(REG_FLASH_INTERVAL, flash_ms);
        write_reg(REG_PULSE_INTERVAL, pulse_ms);
        write_reg(REG_LOW_LEVEL, low);
        write_reg(REG_HIGH_LEVEL, high);
        write_reg(REG_FADE_STEP, step);
        cur_flash_ms = flash_ms;
        cur_pulse_ms = pulse_ms;
    endtask

    // One random sequence. Mostly a command followed by a random number of
    // ticks, capped at 48, sometimes enough for timed flash to run out and the
    // breathing fade to take several steps; sometimes a command cut short by
    // the next one; sometimes a single beat of any code at all, unused codes included.
    task automatic send_sequence();
        int   pick;
        int   ticks;
        t_cmd cmd;
        logic normal;
        pick   = $urandom_range(0, 9);
        normal = 1'($urandom);
        if (pick == 0) begin
            send_beat(3'($urandom), normal);
        end else begin
            cmd = t_cmd'($urandom_range(CMD_ON, CMD_PULSE));
            send_beat(cmd, normal);
            case (cmd)
                CMD_FLASH: ticks = $urandom_range(0, 2 * cur_flash_ms + 3 * cur_pulse_ms + 6);
                CMD_PULSE: ticks = $urandom_range(0, 5 * cur_pulse_ms + 10);
                default:   ticks = $urandom_range(0, 3);
            endcase
            if (pick == 1) ticks = 0;
            if (ticks > 48) ticks = 48;
            repeat (ticks) send_beat(CMD_TICK, 1'($urandom));
        end
    endtask

    task automatic run_phase(input int target, input t_rx_style style, input bit steady,
                             input bit squeeze);
        rx_style    = style;
        tx_steady   = steady;
        phase_items = 0;
        // The long stall starts while the sender keeps offering beats, so
        // the result register fills and the command side backs up.
        if (squeeze) holds_requested++;
        while (phase_items < target) send_sequence();
        drain();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_TICK;
        in_ch.normal_state = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_FLASH_INTERVAL;
        cfg_data           = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings: on and off each drive the
        // LED once and fall back to idle, an idle tick writes nothing, unused
        // codes are ignored, both flash variants start, the inverted pulse
        // command means off, and the normal one breathes once its interval
        // has passed on the pulse timer.
        cur_flash_ms = RST_FLASH_INTERVAL;
        cur_pulse_ms = RST_PULSE_INTERVAL;
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_ON, 1'b0);
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_OFF, 1'b1);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_UNUSED_LO, 1'b1);
        send_beat(CMD_UNUSED_HI, 1'b0);
        send_beat(CMD_FLASH, 1'b1);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_FLASH, 1'b0);
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_PULSE, 1'b0);
        send_beat(CMD_PULSE, 1'b1);
        repeat (6) send_beat(CMD_TICK, 1'b0);
        drain();

        // Zero intervals: flash ends on its first tick and breathing steps on
        // every tick. A write to an index past the last register must change
        // nothing.
        load_settings(0, 0, RST_LOW_LEVEL, RST_HIGH_LEVEL, RST_FADE_STEP);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_beat(CMD_FLASH, 1'b1);
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_FLASH, 1'b0);
        repeat (3) send_beat(CMD_TICK, 1'b1);
        drain();

        // Random phases over a range of settings.
        load_settings(3, 2, 0, 255, 5);
        run_phase(130, RX_SCATTER, 1'b0, 1'b0);
        load_settings(0, 0, 20, 200, 64);
        run_phase(130, RX_RUNS, 1'b0, 1'b0);
        // Crossed limits turn the fade around on every step; this phase
        // also carries the long result-side stall against a steady sender.
        load_settings(5, 1, 255, 0, 7);
        run_phase(130, RX_ALWAYS, 1'b1, 1'b1);
        // A zero step never moves the brightness, equal limits still turn it.
        load_settings(2, 0, 100, 100, 0);
        run_phase(110, RX_SCATTER, 1'b1, 1'b0);
        load_settings(1, 1, 0, 255, 127);
        run_phase(110, RX_RUNS, 1'b0, 1'b0);
        repeat (3) begin
            load_settings($urandom_range(0, 10), $urandom_range(0, 3), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 127));
            run_phase(110, t_rx_style'($urandom_range(RX_ALWAYS, RX_RUNS)), 1'($urandom),
                      1'b0);
        end

        // Largest intervals: a long flash-on stretch lets the pulse timer run
        // into its ceiling, so breathing writes on the first tick after the
        // pulse command and then again only after the full interval.
        load_settings(16'hFFFF, 8'hFF, 0, 255, 1);
        rx_style  = RX_SCATTER;
        tx_steady = 1'b0;
        send_beat(CMD_FLASH, 1'b1);
        repeat (520) send_beat(CMD_TICK, 1'($urandom));
        send_beat(CMD_PULSE, 1'b1);
        repeat (280) send_beat(CMD_TICK, 1'($urandom));
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_led_on_off_breathing_controller_top passed");
        end else begin
            $display("tb_led_on_off_breathing_controller_top failed");
        end
        $finish;
    end

endmodule
